// ===== hw/rtl/scf_pkg.sv =====
`default_nettype none

package scf_pkg;

    // Stream item fields
    localparam int POS_BITS        = 32;
    localparam int SAMPLE_BITS     = 24;
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int GAIN_BITS       = GAIN_FRAC_BITS + 1;
    localparam int RAMP_BITS       = 16;
    localparam int OP_BITS         = 2;

    localparam logic [GAIN_BITS-1:0] FULL_SCALE  = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic [RAMP_BITS-1:0] RAMP_RESET  = 16'd1440;

    // Input tdata: section_end, section_is_loud, sample_left, sample_right
    localparam int IN_END_LSB      = 0;
    localparam int IN_LOUD_BIT     = IN_END_LSB + POS_BITS;
    localparam int IN_LEFT_LSB     = IN_LOUD_BIT + 1;
    localparam int IN_RIGHT_LSB    = IN_LEFT_LSB + SAMPLE_BITS;
    localparam int IN_USED_BITS    = IN_RIGHT_LSB + SAMPLE_BITS;
    localparam int IN_TDATA_BITS   = ((IN_USED_BITS + 7) / 8) * 8;

    // Output tdata: loud_left, loud_right, quiet_left, quiet_right, gain_applied
    localparam int MUL_STEPS       = 4;
    localparam int OUT_USED_BITS   = MUL_STEPS * SAMPLE_BITS + GAIN_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;
    localparam int REG_INDEX_BITS  = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_RAMP_LENGTH = 1'b0;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 2'd0,
        OP_FRAME  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic capture;
        logic append;
        logic clear;
        logic rd_cur;
        logic rd_nxt;
        logic latch_cur;
        logic advance;
        logic gain_zero;
        logic gain_hold_ram;
        logic gain_hold_reg;
        logic div_init;
        logic div_step;
        logic gain_div;
        logic mul_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic adv;
        logic last;
        logic ramp_zero;
        logic ramp_skip;
        logic div_last;
        logic mul_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/scf_ram.sv =====
`default_nettype none

module scf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/scf_datapath.sv =====
`default_nettype none

module scf_datapath #(
    parameter int MAX_SECTIONS = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire scf_pkg::t_cmd                         i_cmd,
    output scf_pkg::t_status                           o_status,
    // section_end, section_is_loud, sample_left, sample_right
    input  wire logic [scf_pkg::IN_TDATA_BITS-1:0]     i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    // loud_left, loud_right, quiet_left, quiet_right, gain_applied
    output logic      [scf_pkg::OUT_TDATA_BITS-1:0]    o_out_data,
    input  wire logic                                  i_psel,
    input  wire logic                                  i_penable,
    input  wire logic                                  i_pwrite,
    input  wire logic [scf_pkg::APB_ADDR_BITS-1:0]     i_paddr,
    input  wire logic [scf_pkg::APB_DATA_BITS-1:0]     i_pwdata,
    output logic      [scf_pkg::APB_DATA_BITS-1:0]     o_prdata
);
    import scf_pkg::*;

    localparam int IW = $clog2(MAX_SECTIONS);
    localparam int CW = IW + 1;
    localparam int EW = POS_BITS + 1;
    localparam int DW = $clog2(GAIN_FRAC_BITS);
    localparam int MW = $clog2(MUL_STEPS + 1);
    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SECTIONS);

    logic [CW-1:0]                 r_count;
    logic [IW-1:0]                 r_idx;
    logic [POS_BITS-1:0]           r_pos;
    logic [RAMP_BITS-1:0]          r_ramp;
    logic signed [SAMPLE_BITS-1:0] r_sl;
    logic signed [SAMPLE_BITS-1:0] r_sr;
    logic [POS_BITS-1:0]           r_cur_end;
    logic                          r_cur_loud;
    logic [RAMP_BITS-1:0]          r_rem;
    logic [GAIN_BITS-1:0]          r_quo;
    logic [DW-1:0]                 r_dcnt;
    logic [GAIN_BITS-1:0]          r_gain;
    logic [MW-1:0]                 r_mcnt;
    logic signed [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0]        r_res [MUL_STEPS];
    logic                          r_out_valid;
    logic [OUT_TDATA_BITS-1:0]     r_out_data;

    logic [EW-1:0]                 rd_data;
    logic [POS_BITS-1:0]           rd_end;
    logic                          rd_loud;
    logic [CW-1:0]                 idx_p1;
    logic                          has_next;
    logic [POS_BITS:0]             to_end;
    logic                          until_gt;
    logic [RAMP_BITS-1:0]          until_u;
    logic [RAMP_BITS-1:0]          ramp_pos;
    logic                          dist_full;
    logic [RAMP_BITS:0]            rem2;
    logic                          rem_ge;
    logic [RAMP_BITS:0]            rem_diff;
    logic [GAIN_BITS-1:0]          quiet_gain;
    logic signed [SAMPLE_BITS-1:0] m_samp;
    logic [GAIN_BITS-1:0]          m_gain;
    logic [1:0]                    res_sel;
    logic                          full;
    logic                          ram_wr;
    logic                          ram_rd;
    logic [IW-1:0]                 ram_rd_addr;
    logic                          cfg_wr;

    assign full        = (r_count == COUNT_MAX);
    assign ram_wr      = i_cmd.append && !full;
    assign ram_rd      = i_cmd.rd_cur || i_cmd.rd_nxt;
    assign idx_p1      = {1'b0, r_idx} + CW'(1);
    assign ram_rd_addr = i_cmd.rd_nxt ? idx_p1[IW-1:0] : r_idx;

    scf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data ({i_in_data[IN_LOUD_BIT], i_in_data[IN_END_LSB +: POS_BITS]}),
        .i_rd_en   (ram_rd),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_end  = rd_data[POS_BITS-1:0];
    assign rd_loud = rd_data[POS_BITS];

    assign has_next = (idx_p1 < r_count);

    // Distance to the boundary, signed; past the boundary clamps to zero
    assign to_end    = {1'b0, r_cur_end} - {1'b0, r_pos};
    assign until_gt  = !to_end[POS_BITS] &&
                       (to_end[POS_BITS-1:0] > {{(POS_BITS-RAMP_BITS){1'b0}}, r_ramp});
    assign until_u   = to_end[POS_BITS] ? '0 : to_end[RAMP_BITS-1:0];
    assign ramp_pos  = r_ramp - until_u;
    assign dist_full = (ramp_pos == r_ramp);

    // One restoring-division bit per step
    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, r_ramp});
    assign rem_diff = rem2 - {1'b0, r_ramp};

    assign quiet_gain = FULL_SCALE - r_gain;
    assign m_samp     = r_mcnt[0] ? r_sr : r_sl;
    assign m_gain     = r_mcnt[1] ? quiet_gain : r_gain;
    assign res_sel    = 2'(r_mcnt - MW'(1));

    assign cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_ramp      <= RAMP_RESET;
            r_gain      <= '0;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && i_paddr[APB_ADDR_BITS-1:2] == REG_RAMP_LENGTH) begin
                r_ramp <= i_pwdata[RAMP_BITS-1:0];
            end
            if (ram_wr) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_idx   <= '0;
                r_pos   <= '0;
            end
            if (i_cmd.advance) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.gain_zero) begin
                r_gain <= '0;
            end
            if (i_cmd.gain_hold_ram) begin
                r_gain <= rd_loud ? FULL_SCALE : '0;
            end
            if (i_cmd.gain_hold_reg) begin
                r_gain <= r_cur_loud ? FULL_SCALE : '0;
            end
            if (i_cmd.gain_div) begin
                r_gain <= r_cur_loud ? FULL_SCALE - r_quo : r_quo;
            end
            if (i_cmd.div_init) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DW'(1);
            end
            if (i_cmd.mul_run) begin
                r_mcnt <= (r_mcnt == MW'(MUL_STEPS)) ? '0 : r_mcnt + MW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_pos       <= r_pos + POS_BITS'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sl <= i_in_data[IN_LEFT_LSB +: SAMPLE_BITS];
            r_sr <= i_in_data[IN_RIGHT_LSB +: SAMPLE_BITS];
        end
        if (i_cmd.latch_cur) begin
            r_cur_end  <= rd_end;
            r_cur_loud <= rd_loud;
        end
        if (i_cmd.div_init) begin
            r_rem <= dist_full ? '0 : ramp_pos;
            r_quo <= GAIN_BITS'(dist_full);
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[RAMP_BITS-1:0] : rem2[RAMP_BITS-1:0];
            r_quo <= {r_quo[GAIN_BITS-2:0], rem_ge};
        end
        if (i_cmd.mul_run) begin
            r_prod <= m_samp * $signed({1'b0, m_gain});
            if (r_mcnt != '0) begin
                r_res[res_sel] <= r_prod[SAMPLE_BITS+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS];
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= {{(OUT_TDATA_BITS-OUT_USED_BITS){1'b0}}, r_gain,
                           r_res[3], r_res[2], r_res[1], r_res[0]};
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.adv        = has_next && (r_pos >= rd_end);
    assign o_status.last       = !has_next;
    assign o_status.ramp_zero  = (r_ramp == '0);
    assign o_status.ramp_skip  = until_gt || (rd_loud == r_cur_loud);
    assign o_status.div_last   = (r_dcnt == DW'(GAIN_FRAC_BITS - 1));
    assign o_status.mul_done   = (r_mcnt == MW'(MUL_STEPS));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_prdata    = (i_paddr[APB_ADDR_BITS-1:2] == REG_RAMP_LENGTH) ?
                         {{(APB_DATA_BITS-RAMP_BITS){1'b0}}, r_ramp} : '0;

    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ({1'b0, r_idx} < r_count))
        else $error("section index beyond loaded entries");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("entry count beyond capacity");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= FULL_SCALE)
        else $error("gain above full scale");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !i_cmd.clear) |=> (r_pos == $past(r_pos) + POS_BITS'(1)))
        else $error("frame position did not advance with result");

endmodule

`default_nettype wire

// ===== hw/rtl/scf_ctrl.sv =====
`default_nettype none

module scf_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [scf_pkg::OP_BITS-1:0] i_op,
    input  wire scf_pkg::t_status            i_status,
    output scf_pkg::t_cmd                    o_cmd
);
    import scf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_CHK_CUR,
        S_RD_NXT,
        S_CHK_NXT,
        S_DIV,
        S_DIV_END,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_adv_done;
    logic   n_adv_done;
    logic   accept;
    t_cmd   cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_adv_done = r_adv_done;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_adv_done = 1'b0;
                    case (t_op'(i_op))
                        OP_APPEND: cmd.append = 1'b1;
                        OP_CLEAR:  cmd.clear  = 1'b1;
                        OP_FRAME: begin
                            cmd.capture = 1'b1;
                            if (i_status.count_zero) begin
                                cmd.gain_zero = 1'b1;
                                n_state       = S_MUL;
                            end else begin
                                n_state = S_RD_CUR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                n_state    = S_CHK_CUR;
            end
            S_CHK_CUR: begin
                cmd.latch_cur = 1'b1;
                // advance at most once per frame, then reread the new entry
                if (!r_adv_done && i_status.adv) begin
                    cmd.advance = 1'b1;
                    n_adv_done  = 1'b1;
                    n_state     = S_RD_CUR;
                end else if (i_status.last || i_status.ramp_zero) begin
                    cmd.gain_hold_ram = 1'b1;
                    n_state           = S_MUL;
                end else begin
                    n_state = S_RD_NXT;
                end
            end
            S_RD_NXT: begin
                cmd.rd_nxt = 1'b1;
                n_state    = S_CHK_NXT;
            end
            S_CHK_NXT: begin
                if (i_status.ramp_skip) begin
                    cmd.gain_hold_reg = 1'b1;
                    n_state           = S_MUL;
                end else begin
                    cmd.div_init = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                cmd.gain_div = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                cmd.mul_run = 1'b1;
                if (i_status.mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_adv_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_adv_done <= n_adv_done;
        end
    end

    assign o_cmd = cmd;

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.append, cmd.clear, cmd.capture}))
        else $error("more than one operation started");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a pending transfer");

    a_single_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.advance |=> !cmd.advance ##1 !cmd.advance)
        else $error("section index advanced twice in one frame");

endmodule

`default_nettype wire

// ===== hw/rtl/section_crossfade_splitter.sv =====
`default_nettype none
// Append and clear transfers leave the input ready; the next transfer is taken in the next cycle.
// An audio frame keeps the input busy until its result loads, which is delayed while an
// earlier result waits on m_axis. The frame runs up to three table reads over one RAM read
// port, 16 restoring-division steps for a ramp gain, and four products through one shared
// 24x18 multiplier.
// Sync reset zeroes entry count, index, position and output valid; ramp_length goes to 1440.

module section_crossfade_splitter #(
    parameter int MAX_SECTIONS = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // section_end[31:0], section_is_loud[32], sample_left[56:33], sample_right[80:57]
    input  wire logic [scf_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    // operation
    input  wire logic [scf_pkg::OP_BITS-1:0]          s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // loud_left[23:0], loud_right[47:24], quiet_left[71:48], quiet_right[95:72],
    // gain_applied[112:96]
    output logic      [scf_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [scf_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [scf_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [scf_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                      pready
);
    import scf_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    scf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    scf_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata)
    );

endmodule

`default_nettype wire
